// File: src/jp2bc_pkg.sv
// Shared types and constants for the JP2/JXL box-chain length finder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package jp2bc_pkg;

  localparam int unsigned CfgWidth = 40;
  localparam int unsigned LenWidth = 40;
  localparam int unsigned BoxWidth = 64;

  localparam logic [CfgWidth-1:0] MaxSpanReset = 40'd268435456;

  localparam logic [31:0] TypeJp2c = 32'h6A70_3263;
  localparam logic [31:0] TypeJxlp = 32'h6A78_6C70;
  localparam logic [31:0] TypeBrob = 32'h6272_6F62;

  localparam logic [BoxWidth-1:0] MinBox  = 64'd8;
  localparam logic [BoxWidth-1:0] MinXbox = 64'd16;

  localparam logic [31:0] SizeZero     = 32'd0;
  localparam logic [31:0] SizeExtended = 32'd1;

  localparam logic [3:0] HdrSizeLast = 4'd3;
  localparam logic [3:0] HdrTypeLast = 4'd7;
  localparam logic [3:0] HdrExtLast  = 4'd15;

  localparam logic VerdictAccept = 1'b0;
  localparam logic VerdictReject = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } jp2bc_in_t;

  typedef struct packed {
    logic                verdict;
    logic [LenWidth-1:0] span_length;
  } jp2bc_out_t;

  typedef struct packed {
    logic                win_short;
    logic [BoxWidth-1:0] avail;
  } jp2bc_win_t;

endpackage

`default_nettype wire

// File: src/jp2bc_window.sv
// Window register holding the clamped max_span, and the room left in the window
// after the current box start. Depends on jp2bc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jp2bc_window
  import jp2bc_pkg::*;
#(
  parameter int unsigned SPAN_BITS = 40
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgWidth-1:0] cfg_data_i,
  input  wire logic [BoxWidth-1:0] box_start_i,
  output jp2bc_win_t               win_o
);

  localparam logic [BoxWidth-1:0] SpanMask = (64'd1 << SPAN_BITS) - 64'd1;

  logic [SPAN_BITS-1:0] win_q, win_d;
  logic [BoxWidth-1:0]  avail_q, avail_d;
  logic [BoxWidth-1:0]  cfg_wide;
  logic [BoxWidth-1:0]  cfg_clamped;

  assign cfg_wide    = BoxWidth'(cfg_data_i);
  assign cfg_clamped = (cfg_wide > SpanMask) ? SpanMask : cfg_wide;
  assign win_d       = cfg_valid_i ? cfg_clamped[SPAN_BITS-1:0] : win_q;
  assign avail_d     = BoxWidth'(win_d) - box_start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= SPAN_BITS'(MaxSpanReset);
      avail_q <= BoxWidth'(MaxSpanReset);
    end else begin
      win_q   <= win_d;
      avail_q <= avail_d;
    end
  end

  assign win_o.win_short = BoxWidth'(win_q) < MinBox;
  assign win_o.avail     = avail_q;

endmodule

`default_nettype wire

// File: src/jp2bc_walker.sv
// Box walker: gathers header bytes, skips payloads and decides accept or reject.
// Depends on jp2bc_pkg and on the window room from jp2bc_window.
`timescale 1ns / 1ps
`default_nettype none

module jp2bc_walker
  import jp2bc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire jp2bc_in_t           in_data_i,
  input  wire jp2bc_win_t          win_i,
  output logic [BoxWidth-1:0]      box_start_o,
  output logic                     res_valid_o,
  output jp2bc_out_t               res_o
);

  logic                walk_done_q, walk_done_d;
  logic [3:0]          hdr_idx_q, hdr_idx_d;
  logic [BoxWidth-1:0] skip_q, skip_d;
  logic [BoxWidth-1:0] box_start_q, box_start_d;
  logic [31:0]         size_q, size_d;
  logic [31:0]         type_q, type_d;
  logic [BoxWidth-1:0] ext_q, ext_d;

  logic                cur_done;
  logic [3:0]          cur_idx;
  logic [BoxWidth-1:0] cur_skip;
  logic [31:0]         size_new, type_new, type_cur;
  logic [BoxWidth-1:0] ext_new;
  logic [BoxWidth-1:0] close_len, close_used, close_end, close_rem;
  logic                is_stream;

  assign size_new   = {size_q[23:0], in_data_i.data_byte};
  assign type_new   = {type_q[23:0], in_data_i.data_byte};
  assign ext_new    = {ext_q[55:0], in_data_i.data_byte};
  assign cur_done   = in_data_i.first_byte ? 1'b0 : walk_done_q;
  assign cur_idx    = in_data_i.first_byte ? 4'd0 : hdr_idx_q;
  assign cur_skip   = in_data_i.first_byte ? '0 : skip_q;
  assign close_len  = (cur_idx == HdrExtLast) ? ext_new : BoxWidth'(size_q);
  assign close_used = (cur_idx == HdrExtLast) ? MinXbox : MinBox;
  assign close_end  = box_start_q + close_len;
  assign close_rem  = win_i.avail - close_len;
  assign type_cur   = (cur_idx == HdrTypeLast) ? type_new : type_q;
  assign is_stream  = (type_cur == TypeJp2c) || (type_cur == TypeJxlp) ||
                      (type_cur == TypeBrob);

  always_comb begin
    logic do_close;
    do_close    = 1'b0;
    walk_done_d = walk_done_q;
    hdr_idx_d   = hdr_idx_q;
    skip_d      = skip_q;
    box_start_d = box_start_q;
    size_d      = size_q;
    type_d      = type_q;
    ext_d       = ext_q;
    res_valid_o = 1'b0;
    res_o.verdict     = VerdictReject;
    res_o.span_length = '0;

    if (accept_i) begin
      if (in_data_i.first_byte) begin
        walk_done_d = 1'b0;
        hdr_idx_d   = 4'd0;
        skip_d      = '0;
        box_start_d = '0;
      end
      if (in_data_i.first_byte && win_i.win_short) begin
        res_valid_o = 1'b1;
      end else if (!cur_done) begin
        if (cur_skip != '0) begin
          skip_d = cur_skip - BoxWidth'(1);
        end else begin
          hdr_idx_d = cur_idx + 4'd1;
          if (cur_idx <= HdrSizeLast) begin
            size_d = size_new;
          end else if (cur_idx <= HdrTypeLast) begin
            type_d = type_new;
          end else begin
            ext_d = ext_new;
          end
          if (cur_idx == HdrSizeLast && size_new == SizeZero) begin
            res_valid_o = 1'b1;
          end
          if (cur_idx == HdrTypeLast) begin
            if (size_q == SizeExtended) begin
              if (win_i.avail < MinXbox) begin
                res_valid_o = 1'b1;
              end else begin
                ext_d = '0;
              end
            end else if (BoxWidth'(size_q) < MinBox ||
                         BoxWidth'(size_q) > win_i.avail) begin
              res_valid_o = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          if (cur_idx == HdrExtLast) begin
            if (ext_new < MinXbox || ext_new > win_i.avail) begin
              res_valid_o = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          if (do_close) begin
            if (is_stream) begin
              res_valid_o       = 1'b1;
              res_o.verdict     = VerdictAccept;
              res_o.span_length = close_end[LenWidth-1:0];
            end else if (close_rem < MinBox) begin
              res_valid_o = 1'b1;
            end else begin
              box_start_d = close_end;
              skip_d      = close_len - close_used;
              hdr_idx_d   = 4'd0;
            end
          end
        end
        if (!res_valid_o && in_data_i.final_byte) begin
          res_valid_o = 1'b1;
        end
      end
      if (res_valid_o) begin
        walk_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_done_q <= 1'b1;
      hdr_idx_q   <= 4'd0;
      skip_q      <= '0;
      box_start_q <= '0;
      size_q      <= '0;
      type_q      <= '0;
      ext_q       <= '0;
    end else begin
      walk_done_q <= walk_done_d;
      hdr_idx_q   <= hdr_idx_d;
      skip_q      <= skip_d;
      box_start_q <= box_start_d;
      size_q      <= size_d;
      type_q      <= type_d;
      ext_q       <= ext_d;
    end
  end

  assign box_start_o = box_start_q;

endmodule

`default_nettype wire

// File: src/jp2bc_out_reg.sv
// Result register that parts the input side from the output handshake.
// Depends on jp2bc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jp2bc_out_reg
  import jp2bc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  wire jp2bc_out_t res_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output jp2bc_out_t out_data_o
);

  logic       out_valid_q;
  jp2bc_out_t out_data_q;

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && res_valid_i) begin
      out_data_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: src/jp2_box_chain_length_finder_core.sv
// Result: shown in the cycle after the byte that decides it is accepted.
// Throughput: one byte per cycle; the single result register stalls input only
// while a result waits and out_ready_i is low.
// Reset: max_span returns to 268435456 and the walk stays idle until a first byte.
// Top level of the box-chain length finder; depends on jp2bc_pkg, jp2bc_window,
// jp2bc_walker and jp2bc_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module jp2_box_chain_length_finder_core
  import jp2bc_pkg::*;
#(
  parameter int unsigned SPAN_BITS = 40
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire jp2bc_in_t           in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output jp2bc_out_t               out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgWidth-1:0] cfg_data_i
);

  jp2bc_win_t          win;
  logic [BoxWidth-1:0] box_start;
  logic                res_valid;
  jp2bc_out_t          res;
  logic                accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  jp2bc_window #(
    .SPAN_BITS(SPAN_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .box_start_i(box_start),
    .win_o      (win)
  );

  jp2bc_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .win_i      (win),
    .box_start_o(box_start),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  jp2bc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: dv/jp2bc_span_checker.sv
// Checker for the JP2/JXL box-chain length finder: watches the byte, result and span
// register channels, predicts each result and compares it. Depends on jp2bc_pkg.
`timescale 1ns / 1ps

module jp2bc_span_checker
  import jp2bc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  jp2bc_in_t           in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  jp2bc_out_t          out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  output int                  fails_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  accepts_o,
  output int                  walked_o
);

  logic [CfgWidth-1:0] span_limit;
  logic [BoxWidth-1:0] box_origin;
  logic [BoxWidth-1:0] payload_left;
  logic [BoxWidth-1:0] ext_field;
  logic [31:0]         size_field;
  logic [31:0]         type_field;
  int                  hdr_count;
  logic                walk_idle;
  logic                verdict_due;
  jp2bc_out_t          verdict_word;
  jp2bc_out_t          awaited_q[$];
  jp2bc_out_t          oldest;
  int                  fails;
  int                  results;
  int                  accepts;
  int                  walked;

  task automatic restart_walk();
    box_origin   = '0;
    payload_left = '0;
    ext_field    = '0;
    size_field   = '0;
    type_field   = '0;
    hdr_count    = 0;
    walk_idle    = 1'b0;
  endtask

  task automatic conclude(input logic verdict, input logic [BoxWidth-1:0] len);
    verdict_due              = 1'b1;
    verdict_word.verdict     = verdict;
    verdict_word.span_length = len[LenWidth-1:0];
    walk_idle                = 1'b1;
  endtask

  // A stream box ends the walk at once; any other box must leave room for one more header.
  task automatic end_of_header(input logic [BoxWidth-1:0] len, input logic [BoxWidth-1:0] used,
                               input logic [BoxWidth-1:0] room);
    logic [BoxWidth-1:0] box_end;
    box_end = box_origin + len;
    if (type_field == TypeJp2c || type_field == TypeJxlp || type_field == TypeBrob) begin
      conclude(VerdictAccept, box_end);
    end else if (room - box_end < MinBox) begin
      conclude(VerdictReject, '0);
    end else begin
      box_origin   = box_end;
      payload_left = len - used;
      hdr_count    = 0;
    end
  endtask

  task automatic walk_byte(input jp2bc_in_t item);
    logic [BoxWidth-1:0] room;
    room         = BoxWidth'(span_limit);
    verdict_due  = 1'b0;
    verdict_word = '0;
    if (item.first_byte) begin
      restart_walk();
    end
    if (item.first_byte && room < MinBox) begin
      walked++;
      conclude(VerdictReject, '0);
    end else if (!walk_idle) begin
      walked++;
      if (payload_left != '0) begin
        payload_left--;
      end else begin
        if (hdr_count < 4) begin
          size_field = {size_field[23:0], item.data_byte};
        end else if (hdr_count < 8) begin
          type_field = {type_field[23:0], item.data_byte};
        end else begin
          ext_field = {ext_field[55:0], item.data_byte};
        end
        hdr_count++;
        if (hdr_count == 4 && size_field == SizeZero) begin
          conclude(VerdictReject, '0);
        end else if (hdr_count == 8) begin
          if (size_field == SizeExtended) begin
            if (room - box_origin < MinXbox) begin
              conclude(VerdictReject, '0);
            end else begin
              ext_field = '0;
            end
          end else if (size_field < MinBox || size_field > room - box_origin) begin
            conclude(VerdictReject, '0);
          end else begin
            end_of_header(BoxWidth'(size_field), 64'd8, room);
          end
        end else if (hdr_count == 16) begin
          if (ext_field < MinXbox || ext_field > room - box_origin) begin
            conclude(VerdictReject, '0);
          end else begin
            end_of_header(ext_field, 64'd16, room);
          end
        end
      end
      if (!verdict_due && item.final_byte) begin
        conclude(VerdictReject, '0);
      end
    end
  endtask

  task automatic report(input string what, input jp2bc_out_t want, input jp2bc_out_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected verdict %0d length %0d, got verdict %0d length %0d",
               $time, what, want.verdict, want.span_length, got.verdict, got.span_length);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_limit = MaxSpanReset;
      restart_walk();
      walk_idle = 1'b1;
      awaited_q.delete();
      fails   = 0;
      results = 0;
      accepts = 0;
      walked  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        span_limit = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        if (out_data_i.verdict == VerdictAccept) begin
          accepts++;
        end
        if (awaited_q.size() == 0) begin
          report("result with nothing pending", '0, out_data_i);
        end else begin
          oldest = awaited_q.pop_front();
          if (oldest.verdict != out_data_i.verdict ||
              oldest.span_length != out_data_i.span_length) begin
            report("result mismatch", oldest, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        walk_byte(in_data_i);
        if (verdict_due) begin
          awaited_q.insert(awaited_q.size(), verdict_word);
        end
      end
    end
    fails_o   <= fails;
    pending_o <= awaited_q.size();
    results_o <= results;
    accepts_o <= accepts;
    walked_o  <= walked;
  end

endmodule

// File: dv/tb.sv
// Top of the box-chain length finder testbench: clock, reset, byte and span register
// stimulus, and the verdict. Depends on jp2bc_pkg, the core and jp2bc_span_checker.
`timescale 1ns / 1ps

module tb;
  import jp2bc_pkg::*;

  localparam int LimitNs = 8_000_000;
  localparam logic [31:0] TypeFtyp = 32'h6674_7970;
  localparam logic [31:0] TypeFree = 32'h6672_6565;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  jp2bc_in_t           in_data;
  logic                out_valid;
  logic                out_ready;
  jp2bc_out_t          out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data;

  int   fails;
  int   pending;
  int   results;
  int   accepts;
  int   walked;
  int   sent = 0;
  int   span_writes = 0;
  bit   steady = 1'b0;
  logic [7:0] pkt_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  jp2_box_chain_length_finder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  jp2bc_span_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fails_o     (fails),
    .pending_o   (pending),
    .results_o   (results),
    .accepts_o   (accepts),
    .walked_o    (walked)
  );

  task automatic send_byte(input logic [7:0] value, input logic first, input logic last);
    int gap;
    gap = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {value, first, last};
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic put_bytes(input logic [63:0] value, input int count);
    for (int k = count - 1; k >= 0; k--) begin
      pkt_q.insert(pkt_q.size(), value[8*k +: 8]);
    end
  endtask

  task automatic send_pkt(input bit with_final);
    int n;
    n = pkt_q.size();
    for (int k = 0; k < n; k++) begin
      send_byte(pkt_q[k], k == 0, with_final && k == n - 1);
    end
    pkt_q.delete();
  endtask

  // Holds the byte channel until every pending result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_span(input logic [CfgWidth-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span_writes++;
  endtask

  // Mostly well-formed box chains ending in a stream box, with broken headers and noise.
  task automatic gen_container();
    int          kind;
    int          plen;
    int          cut;
    bit          with_final;
    logic [31:0] box_kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      repeat ($urandom_range(0, 3)) begin
        plen     = $urandom_range(0, 16);
        box_kind = $urandom;
        if ($urandom_range(0, 4) == 0) begin
          put_bytes(SizeExtended, 4);
          put_bytes(box_kind, 4);
          put_bytes(16 + plen, 8);
        end else begin
          put_bytes(8 + plen, 4);
          put_bytes(box_kind, 4);
        end
        repeat (plen) put_bytes($urandom_range(0, 255), 1);
      end
      case ($urandom_range(0, 2))
        0: box_kind = TypeJp2c;
        1: box_kind = TypeJxlp;
        default: box_kind = TypeBrob;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        put_bytes(SizeExtended, 4);
        put_bytes(box_kind, 4);
        put_bytes($urandom_range(0, 3) == 0 ? {$urandom, $urandom} :
                  64'($urandom_range(16, 80)), 8);
      end else begin
        put_bytes($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(8, 80), 4);
        put_bytes(box_kind, 4);
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, pkt_q.size());
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
        with_final = 1'b1;
      end else begin
        with_final = ($urandom_range(0, 3) == 0);
      end
      send_pkt(with_final);
      repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 255), 1'b0,
                                              $urandom_range(0, 3) == 0);
    end else if (kind < 9) begin
      put_bytes($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom, 4);
      put_bytes($urandom, 4);
      if ($urandom_range(0, 1)) begin
        put_bytes($urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 40)), 8);
      end
      repeat ($urandom_range(0, 6)) put_bytes($urandom, 1);
      cut = $urandom_range(1, pkt_q.size());
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      send_pkt($urandom_range(0, 1));
    end else begin
      repeat ($urandom_range(1, 12)) send_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0,
                                               $urandom_range(0, 7) == 0);
    end
    if ($urandom_range(0, 15) == 0) begin
      settle();
    end
  endtask

  initial begin
    int          target;
    logic [63:0] r64;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_bytes(8, 4); put_bytes(TypeJp2c, 4); send_pkt(1'b1);
    put_bytes(12, 4); put_bytes(TypeFtyp, 4); put_bytes($urandom, 4);
    put_bytes(9, 4); put_bytes(TypeBrob, 4); send_pkt(1'b0);
    send_byte($urandom_range(0, 255), 1'b0, 1'b0);
    send_byte($urandom_range(0, 255), 1'b0, 1'b1);
    put_bytes(SizeExtended, 4); put_bytes(TypeJxlp, 4); put_bytes(16, 8); send_pkt(1'b0);
    put_bytes(SizeZero, 4); send_pkt(1'b0);
    put_bytes(5, 4); put_bytes(TypeFree, 4); send_pkt(1'b0);
    put_bytes(32'hFFFF_FFFF, 4); put_bytes(TypeJp2c, 4); send_pkt(1'b0);
    put_bytes(SizeExtended, 4); put_bytes(TypeFree, 4); put_bytes(15, 8); send_pkt(1'b0);
    put_bytes(SizeExtended, 4); put_bytes(TypeJp2c, 4); put_bytes('1, 8); send_pkt(1'b0);
    put_bytes(0, 2); send_pkt(1'b1);
    put_bytes(20, 4); put_bytes(TypeFree, 4); put_bytes($urandom, 3); send_pkt(1'b1);
    put_bytes(0, 3); send_pkt(1'b0);
    put_bytes(8, 4); put_bytes(TypeJxlp, 4); send_pkt(1'b0);

    write_span('0);
    send_byte($urandom_range(0, 255), 1'b1, 1'b0);
    send_byte($urandom_range(0, 255), 1'b0, 1'b1);
    write_span(7);
    put_bytes(8, 4); put_bytes(TypeJp2c, 4); send_pkt(1'b1);
    write_span(8);
    put_bytes(8, 4); put_bytes(TypeFree, 4); send_pkt(1'b0);
    put_bytes(8, 4); put_bytes(TypeBrob, 4); send_pkt(1'b0);
    write_span(15);
    put_bytes(SizeExtended, 4); put_bytes(TypeJp2c, 4); put_bytes(16, 8); send_pkt(1'b0);
    write_span(20);
    put_bytes(16, 4); put_bytes(TypeFree, 4); put_bytes({$urandom, $urandom}, 8);
    send_pkt(1'b0);
    write_span('1);
    put_bytes(SizeExtended, 4); put_bytes(TypeJp2c, 4); put_bytes(64'hFF_FFFF_FFFF, 8);
    send_pkt(1'b0);
    put_bytes(SizeExtended, 4); put_bytes(TypeJxlp, 4); put_bytes(64'h100_0000_0000, 8);
    send_pkt(1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      r64 = {$urandom, $urandom};
      case (phase)
        0: write_span('1);
        1: write_span($urandom_range(8, 300));
        2: write_span(r64[CfgWidth-1:0]);
        default: write_span($urandom_range(16, 4096));
      endcase
      steady = (phase == 1);
      target = walked + 65;
      while (walked < target && sent < 4000) begin
        gen_container();
      end
    end
    steady = 1'b0;
    settle();

    $display("Span register written %0d times; %0d bytes sent, %0d of them walked.",
             span_writes, sent, walked);
    $display("Results checked: %0d (%0d accepts, %0d rejects).",
             results, accepts, results - accepts);
    if (fails == 0 && pending == 0) begin
      $display("** jp2_box_chain_length_finder_core: PASSED **");
    end else begin
      $display("** jp2_box_chain_length_finder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    int hold;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    #(LimitNs);
    $display("Timeout with %0d results still pending.", pending);
    $display("** jp2_box_chain_length_finder_core: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
src/jp2bc_pkg.sv
src/jp2bc_window.sv
src/jp2bc_walker.sv
src/jp2bc_out_reg.sv
src/jp2_box_chain_length_finder_core.sv
dv/jp2bc_span_checker.sv
dv/tb.sv
